/* sv/key_autorepeat_generator_top_assert.svh */
// Assertion macros for the key autorepeat generator.
// The macros assume the enclosing module has i_clk; KAR_ASSERT also needs i_rst_n.
`ifndef KEY_AUTOREPEAT_GENERATOR_TOP_ASSERT_SVH
`define KEY_AUTOREPEAT_GENERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is held.
`define KAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define KAR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define KAR_ASSERT(lbl, prop, msg)
`define KAR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/kar_pkg.sv */
package kar_pkg;

    localparam int KEY_COUNT_DEF = 32;

    localparam int KEY_W   = 6;
    localparam int FOCUS_W = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;

    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST  = 16'd300;
    localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd30;

    localparam logic CFG_REPEAT_DELAY  = 1'b0;
    localparam logic CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [OP_W-1:0] OP_DOWN  = 2'd0;
    localparam logic [OP_W-1:0] OP_UP    = 2'd1;
    localparam logic [OP_W-1:0] OP_THINK = 2'd2;

    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd2;

    // per-key state carried around the ring
    typedef struct packed {
        logic              held;
        logic [TIME_W-1:0] rpt_time;
    } t_cell;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [FOCUS_W-1:0] target;
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

/* sv/kar_cell.sv */
module kar_cell
    import kar_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_cell i_d,
    output t_cell o_q
);

    logic              r_held;
    logic              n_held;
    logic [TIME_W-1:0] r_rpt_time;
    logic [TIME_W-1:0] n_rpt_time;

    assign n_held     = i_shift ? i_d.held : r_held;
    assign n_rpt_time = i_shift ? i_d.rpt_time : r_rpt_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else begin
            r_held <= n_held;
        end
    end

    // time is only read for held keys, so no reset
    always_ff @(posedge i_clk) begin
        r_rpt_time <= n_rpt_time;
    end

    assign o_q.held     = r_held;
    assign o_q.rpt_time = r_rpt_time;

endmodule

/* sv/kar_update.sv */
module kar_update
    import kar_pkg::*;
(
    input  t_cell              i_cell,
    input  logic [KEY_W-1:0]   i_idx,
    input  logic               i_match,
    input  logic [OP_W-1:0]    i_op,
    input  logic [FOCUS_W-1:0] i_focus,
    input  logic [TIME_W-1:0]  i_now,
    input  logic [CFG_W-1:0]   i_delay,
    input  logic [CFG_W-1:0]   i_period,
    input  logic [FOCUS_W-1:0] i_press_target,
    output t_cell              o_cell,
    output logic               o_set_target,
    output logic               o_ev_valid,
    output t_event             o_ev
);

    logic [TIME_W-1:0] diff;
    logic              past;
    logic              has_focus;

    // wrap-safe: strictly ahead by less than half the range
    assign diff      = i_now - i_cell.rpt_time;
    assign past      = (diff != '0) && !diff[TIME_W-1];
    assign has_focus = (i_focus != '0);

    always_comb begin
        o_cell        = i_cell;
        o_set_target  = 1'b0;
        o_ev_valid    = 1'b0;
        o_ev.kind     = EV_PRESS;
        o_ev.key      = i_idx;
        o_ev.target   = i_focus;
        case (i_op)
            OP_DOWN: begin
                if (i_match && !i_cell.held) begin
                    o_cell.held     = 1'b1;
                    o_cell.rpt_time = i_now + TIME_W'(i_delay);
                    o_set_target    = 1'b1;
                    o_ev_valid      = has_focus;
                    o_ev.kind       = EV_PRESS;
                end
            end
            OP_UP: begin
                if (i_match && i_cell.held) begin
                    o_cell.held = 1'b0;
                    o_ev_valid  = has_focus;
                    o_ev.kind   = EV_RELEASE;
                end
            end
            OP_THINK: begin
                if (has_focus && i_cell.held) begin
                    if (i_press_target != i_focus) begin
                        o_cell.held = 1'b0;
                    end else if (past) begin
                        o_cell.rpt_time = i_now + TIME_W'(i_period);
                        o_ev_valid      = 1'b1;
                        o_ev.kind       = EV_REPEAT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/key_autorepeat_generator_top.sv */
// An accepted word keeps busy high through its scan and flush; its final result, flagged
// by o_last_event, shows in the same cycle that busy falls. The ring turns one key a
// cycle, and a new word is taken only while busy is low. A result waits in a one-deep
// hold for the next one or the scan end before it leaves; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) clears held keys and press target, restores 300 / 30 ms.
`include "key_autorepeat_generator_top_assert.svh"

module key_autorepeat_generator_top
    import kar_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [KEY_W-1:0]   i_key_code,
    input  logic [FOCUS_W-1:0] i_focus_id,
    input  logic [TIME_W-1:0]  i_now_ms,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // result strobe
    output logic               o_event_valid,
    output logic [KIND_W-1:0]  o_event_kind,
    output logic [KEY_W-1:0]   o_event_key,
    output logic [FOCUS_W-1:0] o_event_target,
    output logic               o_last_event
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(KEY_COUNT - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] r_delay;
    logic [CFG_W-1:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= REPEAT_DELAY_RST;
            r_period <= REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_REPEAT_DELAY) begin
                r_delay <= i_cfg_data;
            end else begin
                r_period <= i_cfg_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: IDLE -> SCAN (one key per cycle) -> FLUSH -> IDLE
    // ---------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   scanning;
    logic   flushing;

    logic [IDX_W-1:0] r_idx;

    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == IDX_LAST) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        scanning = 1'b0;
        flushing = 1'b0;
        case (r_state)
            ST_IDLE:  busy     = 1'b0;
            ST_SCAN:  scanning = 1'b1;
            ST_FLUSH: flushing = 1'b1;
            default:  busy     = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx <= '0;
            end else if (scanning) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // captured command word
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [FOCUS_W-1:0] r_focus;
    logic [TIME_W-1:0]  r_now;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_key   <= i_key_code;
            r_focus <= i_focus_id;
            r_now   <= i_now_ms;
        end
    end

    // ---------------------------------------------------------------
    // Key ring: cell 0 is the head. While scanning every cell hands its
    // state to the cell below; the head, after update, re-enters at the
    // tail. After KEY_COUNT shifts cell k again holds key k.
    // ---------------------------------------------------------------
    t_cell ring_q [KEY_COUNT];
    t_cell head_next;

    for (genvar g = 0; g < KEY_COUNT; g++) begin : g_cell
        t_cell cell_d;
        if (g == KEY_COUNT - 1) begin : g_tail
            assign cell_d = head_next;
        end else begin : g_link
            assign cell_d = ring_q[g+1];
        end
        kar_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (scanning),
            .i_d     (cell_d),
            .o_q     (ring_q[g])
        );
    end

    logic [FOCUS_W-1:0] r_press_target;
    logic               set_target;
    logic               ev_valid;
    t_event             ev;
    logic [KEY_W-1:0]   head_key;

    // key_code at or above KEY_COUNT never matches
    assign head_key = KEY_W'(r_idx);

    kar_update u_update (
        .i_cell         (ring_q[0]),
        .i_idx          (head_key),
        .i_match        (head_key == r_key),
        .i_op           (r_op),
        .i_focus        (r_focus),
        .i_now          (r_now),
        .i_delay        (r_delay),
        .i_period       (r_period),
        .i_press_target (r_press_target),
        .o_cell         (head_next),
        .o_set_target   (set_target),
        .o_ev_valid     (ev_valid),
        .o_ev           (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_target <= '0;
        end else if (scanning && set_target) begin
            r_press_target <= r_focus;
        end
    end

    // ---------------------------------------------------------------
    // One-deep event hold: an event is released only once the next one
    // (last = 0) or the end of the scan (last = 1) is known.
    // ---------------------------------------------------------------
    logic   r_pend_valid;
    t_event r_pend;
    logic   r_out_valid;
    logic   r_out_last;
    t_event r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (scanning && ev_valid) begin
                r_pend_valid <= 1'b1;
                r_out_valid  <= r_pend_valid;
            end else if (flushing) begin
                r_pend_valid <= 1'b0;
                r_out_valid  <= r_pend_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scanning && ev_valid) begin
            r_pend     <= ev;
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end else if (flushing) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign o_event_valid  = r_out_valid;
    assign o_event_kind   = r_out.kind;
    assign o_event_key    = r_out.key;
    assign o_event_target = r_out.target;
    assign o_last_event   = r_out_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `KAR_ASSERT(a_target_nonzero, o_event_valid |-> (o_event_target != '0),
        "event sent to no target")
    `KAR_ASSERT(a_idle_no_pend, (r_state == ST_IDLE) |-> !r_pend_valid,
        "event left pending after item finished")
    `KAR_ASSERT(a_last_after_flush,
        (o_event_valid && o_last_event) |-> ($past(r_state) == ST_FLUSH),
        "final event outside flush")
    `KAR_ASSERT(a_scan_ends, (r_state == ST_FLUSH) |=> !busy,
        "flush not followed by idle")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Typematic repeat engine check.
// Words go in over the start/busy handshake; each accepted word is run through a
// local copy of the key state, and the press/release/repeat events that word
// should raise are queued. A monitor compares every strobed event, field by
// field, against the oldest queued one. Registers are only touched while the
// engine is quiet.
module testbench;
    import kar_pkg::*;

    localparam int KEYS = KEY_COUNT_DEF;

    typedef struct packed {
        t_event ev;
        logic   last;
    } t_expected_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_operation;
    logic [KEY_W-1:0]   i_key_code;
    logic [FOCUS_W-1:0] i_focus_id;
    logic [TIME_W-1:0]  i_now_ms;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_event_valid;
    logic [KIND_W-1:0]  o_event_kind;
    logic [KEY_W-1:0]   o_event_key;
    logic [FOCUS_W-1:0] o_event_target;
    logic               o_last_event;

    // local copy of the engine state
    logic               key_down [KEYS];
    logic [TIME_W-1:0]  repeat_due_ms [KEYS];
    logic [FOCUS_W-1:0] press_focus;
    logic [CFG_W-1:0]   delay_ms;
    logic [CFG_W-1:0]   period_ms;

    t_expected_event pending_events[$];
    int unsigned     failures = 0;
    bit              idle_on = 1'b1;

    key_autorepeat_generator_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_key_code     (i_key_code),
        .i_focus_id     (i_focus_id),
        .i_now_ms       (i_now_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_event_valid  (o_event_valid),
        .o_event_kind   (o_event_kind),
        .o_event_key    (o_event_key),
        .o_event_target (o_event_target),
        .o_last_event   (o_last_event)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the engine hangs.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_expected_event make_event(input logic [KIND_W-1:0] kind,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [FOCUS_W-1:0] target);
        t_expected_event e;
        e.ev.kind   = kind;
        e.ev.key    = key;
        e.ev.target = target;
        e.last      = 1'b0;
        return e;
    endfunction

    // Advance the local key state by one word and queue the events it raises.
    function automatic void predict_word(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input logic [FOCUS_W-1:0] focus,
                                         input logic [TIME_W-1:0] now_ms);
        t_expected_event raised[$];
        logic [TIME_W-1:0] lag;
        if ((op == OP_DOWN || op == OP_UP) && key < KEYS) begin
            if (op == OP_DOWN) begin
                // a down on a key already held is ignored, target included
                if (!key_down[key]) begin
                    key_down[key]      = 1'b1;
                    repeat_due_ms[key] = now_ms + TIME_W'(delay_ms);
                    press_focus        = focus;
                    if (focus != '0)
                        raised.push_back(make_event(EV_PRESS, key, focus));
                end
            end else if (key_down[key]) begin
                key_down[key] = 1'b0;
                // release goes to the focus of the up word, not the press target
                if (focus != '0)
                    raised.push_back(make_event(EV_RELEASE, key, focus));
            end
        end else if (op == OP_THINK && focus != '0) begin
            for (int k = 0; k < KEYS; k++) begin
                if (key_down[k]) begin
                    if (press_focus != focus) begin
                        key_down[k] = 1'b0;     // focus moved: drop silently
                    end else begin
                        lag = now_ms - repeat_due_ms[k];
                        // strictly past, modulo-2^32 signed sense
                        if (lag != '0 && !lag[TIME_W-1]) begin
                            repeat_due_ms[k] = now_ms + TIME_W'(period_ms);
                            raised.push_back(make_event(EV_REPEAT, KEY_W'(k), focus));
                        end
                    end
                end
            end
        end
        if (raised.size() != 0)
            raised[raised.size()-1].last = 1'b1;
        foreach (raised[i])
            pending_events.push_back(raised[i]);
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            failures++;
        end
    endtask

    // Event monitor: one strobe per cycle, no back-pressure.
    always @(posedge i_clk) begin
        t_expected_event want;
        if (i_rst_n === 1'b1 && o_event_valid !== 1'b0) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event: expected none, got kind %0d key %0d target %0d",
                         $time, o_event_kind, o_event_key, o_event_target);
                failures++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", 8'(want.ev.kind), 8'(o_event_kind));
                check_field("event_key", 8'(want.ev.key), 8'(o_event_key));
                check_field("event_target", want.ev.target, o_event_target);
                check_field("last_event", 8'(want.last), 8'(o_last_event));
            end
        end
    end

    // Present one word and hold it until the engine takes it.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [FOCUS_W-1:0] focus, input logic [TIME_W-1:0] now_ms);
        start       <= 1'b1;
        i_operation <= op;
        i_key_code  <= key;
        i_focus_id  <= focus;
        i_now_ms    <= now_ms;
        do @(posedge i_clk); while (busy);
        predict_word(op, key, focus, now_ms);
    endtask

    // Random sender gap; sometimes lands right after busy drops.
    task automatic maybe_pause();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                @(posedge i_clk);
                while (busy) @(posedge i_clk);
            end
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Wait out every queued event plus one full scan for words with no events.
    task automatic drain_events();
        start <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (KEYS + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == CFG_REPEAT_DELAY)
            delay_ms = value;
        else
            period_ms = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Press/release paths and the words that must be ignored.
    task automatic test_press_and_release();
        send_word(OP_DOWN, 6'd0, 8'd1, 32'd0);
        send_word(OP_DOWN, 6'd0, 8'd4, 32'd5);      // already held
        send_word(OP_UP, 6'd0, 8'd5, 32'd10);       // release to current focus
        send_word(OP_UP, 6'd0, 8'd5, 32'd11);       // key already free
        send_word(OP_DOWN, 6'd31, 8'd0, 32'd20);    // held but no target
        send_word(OP_UP, 6'd31, 8'd255, 32'd21);
        send_word(OP_DOWN, 6'd32, 8'd1, 32'd22);    // beyond the key range
        send_word(OP_UP, 6'd63, 8'd1, 32'd23);
        send_word(2'd3, 6'd1, 8'd1, 32'd24);        // unused opcode
    endtask

    // Repeat timing: exact due time, wrap of the clock, half-range lag, focus loss.
    task automatic test_repeat_timing();
        send_word(OP_DOWN, 6'd3, 8'd7, 32'd1000);
        send_word(OP_THINK, 6'd0, 8'd0, 32'd5000);  // no focus
        send_word(OP_THINK, 6'd0, 8'd7, 32'd1300);  // due, not yet past
        send_word(OP_THINK, 6'd0, 8'd7, 32'd1301);
        send_word(OP_DOWN, 6'd10, 8'd7, 32'hFFFF_FF00);
        send_word(OP_THINK, 6'd0, 8'd7, 32'h0000_0040);
        send_word(OP_THINK, 6'd0, 8'd7, 32'h8000_0600);
        send_word(OP_THINK, 6'd63, 8'd7, 32'h0000_0600);
        send_word(OP_THINK, 6'd0, 8'd9, 32'h0000_0700);  // focus moved: keys dropped
        send_word(OP_THINK, 6'd0, 8'd9, 32'h0000_0800);
    endtask

    // Register extremes, including zero delay and zero period.
    task automatic test_register_extremes();
        drain_events();
        write_reg(CFG_REPEAT_DELAY, 16'd1);
        write_reg(CFG_REPEAT_PERIOD, 16'hFFFF);
        send_word(OP_DOWN, 6'd5, 8'd3, 32'd100);
        send_word(OP_THINK, 6'd0, 8'd3, 32'd102);
        drain_events();
        write_reg(CFG_REPEAT_DELAY, 16'd0);
        write_reg(CFG_REPEAT_PERIOD, 16'd0);
        send_word(OP_DOWN, 6'd6, 8'd3, 32'd300);
        send_word(OP_THINK, 6'd0, 8'd3, 32'd300);
        send_word(OP_THINK, 6'd0, 8'd3, 32'd301);
        drain_events();
        write_reg(CFG_REPEAT_DELAY, 16'hFFFF);
        send_word(OP_DOWN, 6'd7, 8'd3, 32'd400);
    endtask

    // Random traffic in three register settings; mostly steady focus and
    // advancing time so held keys get to repeat.
    task automatic test_random_traffic();
        logic [TIME_W-1:0]  wall_ms;
        logic [FOCUS_W-1:0] cur_focus;
        logic [FOCUS_W-1:0] focus;
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        int unsigned        step_max;
        int unsigned        pick;
        wall_ms   = $urandom;
        cur_focus = 8'd3;
        step_max  = 120;
        for (int n = 0; n < 100; n++) begin
            if (n % 34 == 0) begin
                drain_events();     // sender holds until every event is back
                case (n / 34)
                    0: begin
                        write_reg(CFG_REPEAT_DELAY, REPEAT_DELAY_RST);
                        write_reg(CFG_REPEAT_PERIOD, REPEAT_PERIOD_RST);
                        step_max = 120;
                    end
                    1: begin
                        write_reg(CFG_REPEAT_DELAY, CFG_W'($urandom_range(1, 600)));
                        write_reg(CFG_REPEAT_PERIOD, 16'd1);
                        step_max = 300;
                    end
                    default: begin
                        write_reg(CFG_REPEAT_DELAY, CFG_W'($urandom_range(1, 65535)));
                        write_reg(CFG_REPEAT_PERIOD, CFG_W'($urandom_range(1, 65535)));
                        step_max = 40000;
                    end
                endcase
            end
            if (n >= 85)
                idle_on = 1'b0;     // closing stretch runs back to back
            if ($urandom_range(0, 99) < 4)
                cur_focus = FOCUS_W'($urandom_range(1, 255));
            pick = $urandom_range(0, 99);
            if (pick < 90)
                focus = cur_focus;
            else if (pick < 95)
                focus = '0;
            else
                focus = FOCUS_W'($urandom_range(0, 255));
            key  = KEY_W'($urandom_range(0, KEYS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                op = OP_DOWN;
            end else if (pick < 58) begin
                op = OP_UP;
            end else if (pick < 95) begin
                op  = OP_THINK;
                key = KEY_W'($urandom_range(0, 63));
            end else begin
                // noise: unused opcode or a key past the end
                op  = ($urandom_range(0, 1) == 1) ? 2'd3 : OP_W'($urandom_range(0, 1));
                key = KEY_W'($urandom_range(KEYS, 63));
            end
            if ($urandom_range(0, 49) == 0)
                wall_ms = $urandom;
            else
                wall_ms = wall_ms + $urandom_range(0, step_max);
            send_word(op, key, focus, wall_ms);
            maybe_pause();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_DOWN;
        i_key_code  <= '0;
        i_focus_id  <= '0;
        i_now_ms    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_REPEAT_DELAY;
        i_cfg_data  <= '0;
        // model reset state
        foreach (key_down[k]) begin
            key_down[k]      = 1'b0;
            repeat_due_ms[k] = '0;
        end
        press_focus = '0;
        delay_ms    = REPEAT_DELAY_RST;
        period_ms   = REPEAT_PERIOD_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_press_and_release();
        test_repeat_timing();
        test_register_extremes();
        test_random_traffic();
        drain_events();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* key_autorepeat_generator_top.f */
+incdir+sv
sv/kar_pkg.sv
sv/kar_cell.sv
sv/kar_update.sv
sv/key_autorepeat_generator_top.sv
tb/testbench.sv
